### rtl/s3rp_pkg.sv
// -----------------------------------------------------------------------------
// SHA-256 round precompute package
// Shared types, widths, round constants and the SHA-256 round functions.
// -----------------------------------------------------------------------------
package s3rp_pkg;

	localparam int WORD_W          = 32;
	localparam int MSG_WORDS       = 3;
	localparam int ROUND_COUNT_DEF = 3;
	localparam int IN_DATA_W       = 11 * WORD_W;
	localparam int OUT_DATA_W      = 8 * WORD_W;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t h;
		word_t g;
		word_t f;
		word_t e;
		word_t d;
		word_t c;
		word_t b;
		word_t a;
	} work_state_t;

	typedef word_t [MSG_WORDS-1:0] msg_words_t;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t choose(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic word_t majority(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

### rtl/sha256_three_round_precompute.sv
// -----------------------------------------------------------------------------
// SHA-256 three-round precompute
// Runs the first SHA-256 compression rounds of a block on a midstate.
// -----------------------------------------------------------------------------
// The block takes one request per cycle while the output is not stalled and
// returns the results in order, one compression round per registered pipeline
// stage. The clock rate is set by the round adder chain of a single stage.
// Rounds beyond the third use a message word of zero. When the output is
// stalled the pipeline fills its empty stages before it holds off requests.
module sha256_three_round_precompute import s3rp_pkg::*; #(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h,
	// msg_word0, msg_word1, msg_word2
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic        stage_valid [ROUND_COUNT+1];
	logic        stage_ready [ROUND_COUNT+1];
	work_state_t stage_state [ROUND_COUNT+1];
	msg_words_t  stage_msg   [ROUND_COUNT+1];

	assign stage_valid[0] = s_axis_tvalid;
	assign s_axis_tready  = stage_ready[0];
	assign stage_state[0] = work_state_t'(s_axis_tdata[OUT_DATA_W-1:0]);
	assign stage_msg[0]   = msg_words_t'(s_axis_tdata[IN_DATA_W-1:OUT_DATA_W]);

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
		s3rp_stage #(
			.ROUND_IDX(i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[i]),
			.in_ready  (stage_ready[i]),
			.in_state  (stage_state[i]),
			.in_msg    (stage_msg[i]),
			.out_valid (stage_valid[i+1]),
			.out_ready (stage_ready[i+1]),
			.out_state (stage_state[i+1]),
			.out_msg   (stage_msg[i+1])
		);
	end

	assign stage_ready[ROUND_COUNT] = m_axis_tready;
	assign m_axis_tvalid            = stage_valid[ROUND_COUNT];
	assign m_axis_tdata             = stage_state[ROUND_COUNT];

endmodule

### rtl/s3rp_stage.sv
// -----------------------------------------------------------------------------
// SHA-256 round stage
// One compression round followed by an elastic pipeline register.
// -----------------------------------------------------------------------------
module s3rp_stage import s3rp_pkg::*; #(
	parameter int ROUND_IDX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  work_state_t in_state,
	input  msg_words_t  in_msg,
	output logic        out_valid,
	input  logic        out_ready,
	output work_state_t out_state,
	output msg_words_t  out_msg
);

	localparam logic [5:0] KIdx   = 6'(ROUND_IDX);
	localparam word_t      KVal   = ROUND_K[KIdx];
	localparam bit         UseMsg = (ROUND_IDX < MSG_WORDS);
	localparam logic [1:0] MsgSel = UseMsg ? 2'(ROUND_IDX) : 2'd0;

	logic        valid_s1;
	work_state_t state_s1;
	msg_words_t  msg_s1;
	word_t       msg_word;
	word_t       t1;
	word_t       t2;
	work_state_t next_state;

	assign msg_word = UseMsg ? in_msg[MsgSel] : '0;

	always_comb begin
		t1 = in_state.h + big_sigma1(in_state.e)
			+ choose(in_state.e, in_state.f, in_state.g) + KVal + msg_word;
		t2 = big_sigma0(in_state.a) + majority(in_state.a, in_state.b, in_state.c);
		next_state.h = in_state.g;
		next_state.g = in_state.f;
		next_state.f = in_state.e;
		next_state.e = in_state.d + t1;
		next_state.d = in_state.c;
		next_state.c = in_state.b;
		next_state.b = in_state.a;
		next_state.a = t1 + t2;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			state_s1 <= next_state;
			msg_s1   <= in_msg;
		end
	end

	assign out_valid = valid_s1;
	assign out_state = state_s1;
	assign out_msg   = msg_s1;

endmodule

### rtl/s3rp_checker.sv
// -----------------------------------------------------------------------------
// SHA-256 round precompute checker
// Port-level checks on occupancy, flow control and output stability.
// -----------------------------------------------------------------------------
module s3rp_checker import s3rp_pkg::*; #(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int CntW = $clog2(ROUND_COUNT + 1);
	localparam logic [CntW-1:0] Depth = CntW'(ROUND_COUNT);

	logic            in_fire;
	logic            out_fire;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] unused_in;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_fire  = m_axis_tvalid && m_axis_tready;
	assign unused_in = CntW'(s_axis_tdata[CntW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire && !out_fire) begin
			count_q <= count_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			count_q <= count_q - 1'b1;
		end
	end

	// The pipeline never holds more requests than it has stages.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Depth)
		else $error("more requests in flight than pipeline stages");

	// A result is only shown when a request is in flight.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (count_q != '0))
		else $error("result shown with no request in flight");

	// Requests are refused only when every stage is full and the output stalls.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == ((count_q != Depth) || m_axis_tready || (unused_in != unused_in)))
		else $error("input ready does not follow pipeline occupancy");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind sha256_three_round_precompute s3rp_checker #(
	.ROUND_COUNT(ROUND_COUNT)
) u_s3rp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
